// ===== rtl/wqs_pkg.sv =====
package wqs_pkg;

	// Field widths of the request and response words.
	localparam int REQ_W       = 2;
	localparam int NODE_IDX_W  = 4;
	localparam int VALUE_W     = 24;
	localparam int OUT_NODE_W  = 4;

	// Configuration port.
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int REG16_W     = 16;
	localparam int TOTAL_W     = 24;

	// Default sizes.
	localparam int NODES_DEF      = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int AGE_BITS_DEF   = 32;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_SET_COUNT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SET_GEN   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DECIDE    = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_WORK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REFILL_LEVEL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REFILL_MASK  = 3'd4;

	localparam logic [REG16_W-1:0] CAPACITY_RST = 16'd1024;

	// Sequencer to scan unit control.
	typedef struct packed {
		logic clear;
		logic step;
	} scan_ctrl_t;

	// Scan unit status toward the sequencer.
	typedef struct packed {
		logic entry_free;
		logic forced;
	} scan_flags_t;

endpackage

// ===== rtl/wqs_req_if.sv =====
interface wqs_req_if;
	import wqs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [REQ_W-1:0]      req_type;
	logic [NODE_IDX_W-1:0] node_index;
	logic [VALUE_W-1:0]    count_value;

	modport source(output valid, req_type, node_index, count_value, input ready);
	modport sink(input valid, req_type, node_index, count_value, output ready);

endinterface

// ===== rtl/wqs_rsp_if.sv =====
interface wqs_rsp_if;
	import wqs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OUT_NODE_W-1:0] serve_node;
	logic                  admit_work;
	logic                  fair_forced;

	modport source(output valid, serve_node, admit_work, fair_forced, input ready);
	modport sink(input valid, serve_node, admit_work, fair_forced, output ready);

endinterface

// ===== rtl/wavefront_queue_scheduler.sv =====
// Work-queue scheduler. Set-count and set-generated words are handled in the idle
// state. For a decide word the count and age memories share one read port that a
// sequencer walks one node per cycle, a scan unit folds each node into the running
// maximum, sum and overdue search and writes back its new age, and a finish step,
// which waits while a response is still unread, clears the chosen node's age
// and forms the admission flag. Both memories reset to zero through per-entry
// valid bits, so there is no clearing pass after reset. The response register
// frees the input side: the next word is taken while a response still waits.
module wavefront_queue_scheduler #(
	parameter int NODES      = wqs_pkg::NODES_DEF,
	parameter int COUNT_BITS = wqs_pkg::COUNT_BITS_DEF,
	parameter int AGE_BITS   = wqs_pkg::AGE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	wqs_req_if.sink                          req,
	wqs_rsp_if.source                        rsp,
	input  logic                             cfg_we,
	input  logic [wqs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wqs_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import wqs_pkg::*;

	localparam int NODE_W = $clog2(NODES);
	localparam int LIVE_W = COUNT_BITS + NODE_W;
	localparam int LCMP_W = (LIVE_W + 1 > REG16_W) ? LIVE_W + 1 : REG16_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]            state_q;
	logic [NODE_W-1:0]     idx_q;
	logic [NODE_W-1:0]     idx_s1;
	logic                  step_s1;
	logic [TOTAL_W-1:0]    gen_q;
	logic [TOTAL_W-1:0]    total_work_q;
	logic [REG16_W-1:0]    capacity_q;
	logic [REG16_W-1:0]    refill_level_q;
	logic [REG16_W-1:0]    max_wait_q;
	logic [REG16_W-1:0]    refill_mask_q;
	logic                  rsp_v_q;
	logic [OUT_NODE_W-1:0] sel_q;
	logic                  admit_q;
	logic                  forced_q;

	logic                  accept;
	logic                  fin_go;
	logic                  cnt_we;
	logic [NODE_W-1:0]     cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic                  age_we;
	logic [NODE_W-1:0]     age_waddr;
	logic [AGE_BITS-1:0]   age_wdata;
	logic                  rd_en;
	logic [COUNT_BITS-1:0] cnt_rdata;
	logic [AGE_BITS-1:0]   age_rdata;
	logic [AGE_BITS-1:0]   age_next;
	logic [NODE_W-1:0]     sel;
	logic [LIVE_W-1:0]     live;
	scan_ctrl_t            scan_ctrl;
	scan_flags_t           scan_flags;
	logic [REG16_W-1:0]    thresh;
	logic                  below;
	logic                  aligned;
	logic                  admit;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign fin_go    = (state_q == ST_FIN) && (!rsp_v_q || rsp.ready);

	// Queue count writes, saturated to the count width.
	assign cnt_we    = accept && (req.req_type == REQ_SET_COUNT) &&
		(32'(req.node_index) < NODES);
	assign cnt_waddr = NODE_W'(req.node_index);
	assign cnt_wdata = ((req.count_value >> COUNT_BITS) != '0) ?
		'1 : COUNT_BITS'(req.count_value);

	// Age writes come from the scan, then one clear of the chosen node.
	assign age_we    = step_s1 || (fin_go && sel != '0);
	assign age_waddr = step_s1 ? idx_s1 : sel;
	assign age_wdata = step_s1 ? age_next : '0;
	assign rd_en     = (state_q == ST_SCAN);

	assign scan_ctrl.clear = accept && (req.req_type == REQ_DECIDE);
	assign scan_ctrl.step  = step_s1;

	wqs_store #(
		.NODES      (NODES),
		.COUNT_BITS (COUNT_BITS),
		.AGE_BITS   (AGE_BITS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cnt_we    (cnt_we),
		.cnt_waddr (cnt_waddr),
		.cnt_wdata (cnt_wdata),
		.age_we    (age_we),
		.age_waddr (age_waddr),
		.age_wdata (age_wdata),
		.rd_en     (rd_en),
		.rd_addr   (idx_q),
		.cnt_rdata (cnt_rdata),
		.age_rdata (age_rdata)
	);

	wqs_scan_unit #(
		.NODES      (NODES),
		.COUNT_BITS (COUNT_BITS),
		.AGE_BITS   (AGE_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (scan_ctrl),
		.idx      (idx_s1),
		.cnt      (cnt_rdata),
		.age      (age_rdata),
		.max_wait (max_wait_q),
		.age_next (age_next),
		.sel      (sel),
		.live     (live),
		.flags    (scan_flags)
	);

	// Admission test on the finished scan.
	assign thresh = (refill_level_q < capacity_q) ? refill_level_q : capacity_q;

	always_comb begin
		if (refill_level_q == '0) begin
			below = LCMP_W'({live, 1'b0}) < LCMP_W'(capacity_q);
		end else begin
			below = LCMP_W'(live) < LCMP_W'(thresh);
		end
	end

	// Only the first sixteen nodes have a mask bit.
	always_comb begin
		aligned = (refill_mask_q == '0) || (sel == '0);
		for (int i = 0; i < REG16_W; i++) begin
			if (32'(sel) == i && refill_mask_q[i]) begin
				aligned = 1'b1;
			end
		end
	end

	assign admit = (gen_q < total_work_q) && scan_flags.entry_free && aligned &&
		(live == '0 || below);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			idx_s1  <= '0;
			step_s1 <= 1'b0;
			gen_q   <= '0;
		end else begin
			step_s1 <= (state_q == ST_SCAN);
			idx_s1  <= idx_q;
			case (state_q)
				ST_IDLE: begin
					if (accept && req.req_type == REQ_SET_GEN) begin
						gen_q <= req.count_value;
					end
					if (accept && req.req_type == REQ_DECIDE) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == NODE_W'(NODES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_work_q   <= '0;
			capacity_q     <= CAPACITY_RST;
			refill_level_q <= '0;
			max_wait_q     <= '0;
			refill_mask_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TOTAL_WORK:   total_work_q   <= TOTAL_W'(cfg_data);
				CFG_CAPACITY:     capacity_q     <= REG16_W'(cfg_data);
				CFG_REFILL_LEVEL: refill_level_q <= REG16_W'(cfg_data);
				CFG_MAX_WAIT:     max_wait_q     <= REG16_W'(cfg_data);
				CFG_REFILL_MASK:  refill_mask_q  <= REG16_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (fin_go) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			sel_q    <= OUT_NODE_W'(sel);
			admit_q  <= admit;
			forced_q <= scan_flags.forced;
		end
	end

	assign rsp.valid       = rsp_v_q;
	assign rsp.serve_node  = sel_q;
	assign rsp.admit_work  = admit_q;
	assign rsp.fair_forced = forced_q;

	// A response appears only out of the finish step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_v_q) |-> $past(state_q == ST_FIN))
		else $error("response raised outside the finish step");

	// Queue counts never change under a running scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cnt_we)
		else $error("queue count written during a decision");

	// The drain step leads straight to the finish step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_FIN))
		else $error("drain step did not lead to finish");

	// A fairness override always names a continuation node.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && scan_flags.forced) |-> (sel != '0))
		else $error("forced choice without a node");

endmodule

// ===== rtl/wqs_store.sv =====
module wqs_store #(
	parameter int NODES      = wqs_pkg::NODES_DEF,
	parameter int COUNT_BITS = wqs_pkg::COUNT_BITS_DEF,
	parameter int AGE_BITS   = wqs_pkg::AGE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cnt_we,
	input  logic [$clog2(NODES)-1:0]  cnt_waddr,
	input  logic [COUNT_BITS-1:0]     cnt_wdata,
	input  logic                      age_we,
	input  logic [$clog2(NODES)-1:0]  age_waddr,
	input  logic [AGE_BITS-1:0]       age_wdata,
	input  logic                      rd_en,
	input  logic [$clog2(NODES)-1:0]  rd_addr,
	output logic [COUNT_BITS-1:0]     cnt_rdata,
	output logic [AGE_BITS-1:0]       age_rdata
);
	import wqs_pkg::*;

	logic [COUNT_BITS-1:0] cnt_mem_q [NODES];
	logic [AGE_BITS-1:0]   age_mem_q [NODES];
	logic [NODES-1:0]      cnt_vld_q;
	logic [NODES-1:0]      age_vld_q;
	logic [COUNT_BITS-1:0] cnt_raw_q;
	logic [AGE_BITS-1:0]   age_raw_q;
	logic                  cnt_rvld_q;
	logic                  age_rvld_q;

	// Memory writes and registered reads.
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem_q[cnt_waddr] <= cnt_wdata;
		end
		if (age_we) begin
			age_mem_q[age_waddr] <= age_wdata;
		end
		if (rd_en) begin
			cnt_raw_q <= cnt_mem_q[rd_addr];
			age_raw_q <= age_mem_q[rd_addr];
		end
	end

	// Per-entry valid bits stand in for the all-zero reset of both stores.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q  <= '0;
			age_vld_q  <= '0;
			cnt_rvld_q <= 1'b0;
			age_rvld_q <= 1'b0;
		end else begin
			if (cnt_we) begin
				cnt_vld_q[cnt_waddr] <= 1'b1;
			end
			if (age_we) begin
				age_vld_q[age_waddr] <= 1'b1;
			end
			if (rd_en) begin
				cnt_rvld_q <= cnt_vld_q[rd_addr];
				age_rvld_q <= age_vld_q[rd_addr];
			end
		end
	end

	assign cnt_rdata = cnt_rvld_q ? cnt_raw_q : '0;
	assign age_rdata = age_rvld_q ? age_raw_q : '0;

endmodule

// ===== rtl/wqs_scan_unit.sv =====
module wqs_scan_unit #(
	parameter int NODES      = wqs_pkg::NODES_DEF,
	parameter int COUNT_BITS = wqs_pkg::COUNT_BITS_DEF,
	parameter int AGE_BITS   = wqs_pkg::AGE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  wqs_pkg::scan_ctrl_t                     ctrl,
	input  logic [$clog2(NODES)-1:0]                idx,
	input  logic [COUNT_BITS-1:0]                   cnt,
	input  logic [AGE_BITS-1:0]                     age,
	input  logic [wqs_pkg::REG16_W-1:0]             max_wait,
	output logic [AGE_BITS-1:0]                     age_next,
	output logic [$clog2(NODES)-1:0]                sel,
	output logic [COUNT_BITS+$clog2(NODES)-1:0]     live,
	output wqs_pkg::scan_flags_t                    flags
);
	import wqs_pkg::*;

	localparam int NODE_W = $clog2(NODES);
	localparam int LIVE_W = COUNT_BITS + NODE_W;
	localparam int CMP_W  = (AGE_BITS > REG16_W) ? AGE_BITS : REG16_W;

	logic [COUNT_BITS-1:0] best_q;
	logic [NODE_W-1:0]     best_idx_q;
	logic [AGE_BITS-1:0]   oldest_q;
	logic [NODE_W-1:0]     over_idx_q;
	logic [LIVE_W-1:0]     live_q;
	logic                  free_q;
	logic                  is_entry;
	logic                  overdue;

	assign is_entry = (idx == '0);

	// A non-empty queue whose age has reached the limit and beats the oldest so far.
	assign overdue = (max_wait != '0) && (cnt != '0) &&
		(CMP_W'(age) >= CMP_W'(max_wait)) && (age > oldest_q);

	// Age after this decision, before the selected node is cleared.
	always_comb begin
		if (is_entry || cnt == '0) begin
			age_next = '0;
		end else if (&age) begin
			age_next = age;
		end else begin
			age_next = age + 1'b1;
		end
	end

	// Running maximum, running sum and overdue search, one node per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= '0;
			best_idx_q <= '0;
			oldest_q   <= '0;
			over_idx_q <= '0;
			live_q     <= '0;
			free_q     <= 1'b0;
		end else if (ctrl.clear) begin
			best_q     <= '0;
			best_idx_q <= '0;
			oldest_q   <= '0;
			over_idx_q <= '0;
			live_q     <= '0;
			free_q     <= 1'b0;
		end else if (ctrl.step) begin
			if (is_entry) begin
				free_q <= (cnt != '0);
			end else begin
				if (cnt > best_q) begin
					best_q     <= cnt;
					best_idx_q <= idx;
				end
				if (overdue) begin
					oldest_q   <= age;
					over_idx_q <= idx;
				end
				live_q <= live_q + LIVE_W'(cnt);
			end
		end
	end

	assign sel              = (over_idx_q != '0) ? over_idx_q : best_idx_q;
	assign live             = live_q;
	assign flags.forced     = (over_idx_q != '0);
	assign flags.entry_free = free_q;

endmodule
